[hw/rtl/bdfa_pkg.sv]
// Package for the boundary-descriptor fit allocator.
// Holds sizes, block-table entry and cell control types, and codes.
// No dependencies.
package bdfa_pkg;

  localparam int unsigned MAX_BLOCKS   = 16;
  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned ADDR_BITS    = 20;

  localparam int unsigned LEN_BITS     = ADDR_BITS + 1;
  localparam int unsigned END_BITS     = ADDR_BITS + 2;
  localparam int unsigned POS_BITS     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_BITS     = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned POOL_BITS    = 20;
  localparam int unsigned FIT_BITS     = 2;
  localparam int unsigned STATUS_BITS  = 2;

  localparam logic [POOL_BITS-1:0] POOL_RESET = POOL_BITS'(65536);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_POOL_BYTES = 2'd0,
    REG_FIT_MODE   = 2'd1
  } cfg_reg_e;

  typedef enum logic [FIT_BITS-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_mode_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOMEM     = 2'd1,
    STATUS_NOT_OWNED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  len;
  } entry_t;

  typedef struct packed {
    cell_op_e            op;
    logic [POS_BITS-1:0] pos;
    entry_t              ins;
  } cell_ctrl_t;

endpackage

[hw/rtl/bdfa_req_if.sv]
// Request channel of the allocator: opcode, request size, offset to free.
// Depends on bdfa_pkg.
interface bdfa_req_if;
  import bdfa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [ADDR_BITS-1:0] request_bytes;
  logic [ADDR_BITS-1:0] free_offset;

  modport source (output valid, opcode, request_bytes, free_offset, input ready);
  modport sink   (input valid, opcode, request_bytes, free_offset, output ready);
endinterface

[hw/rtl/bdfa_rsp_if.sv]
// Response channel of the allocator: status and user offset.
// Depends on bdfa_pkg.
interface bdfa_rsp_if;
  import bdfa_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [ADDR_BITS-1:0]   user_offset;

  modport source (output valid, status, user_offset, input ready);
  modport sink   (input valid, status, user_offset, output ready);
endinterface

[hw/rtl/bdfa_cfg_if.sv]
// Configuration write channel of the allocator: register index and data.
// Depends on bdfa_pkg.
interface bdfa_cfg_if;
  import bdfa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] reg_index;
  logic [POOL_BITS-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/bdfa_cell.sv]
// One block-table cell: holds one entry, rotates, inserts or deletes
// through its neighbors. Depends on bdfa_pkg.
module bdfa_cell (
  input  logic                          clk_i,
  input  logic [bdfa_pkg::POS_BITS-1:0] idx_i,
  input  bdfa_pkg::cell_ctrl_t          ctrl_i,
  input  bdfa_pkg::entry_t              prev_i,
  input  bdfa_pkg::entry_t              next_i,
  output bdfa_pkg::entry_t              entry_o
);
  import bdfa_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_HOLD:   entry_d = entry_q;
      CELL_ROTATE: entry_d = next_i;
      CELL_INSERT: begin
        if (idx_i == ctrl_i.pos) begin
          entry_d = ctrl_i.ins;
        end else if (idx_i > ctrl_i.pos) begin
          entry_d = prev_i;
        end
      end
      CELL_DELETE: begin
        if (idx_i >= ctrl_i.pos) begin
          entry_d = next_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[hw/rtl/bdfa_ctrl.sv]
// Sequencer of the allocator: gap scan over the rotating cell row, fit
// choice, free lookup, commit and response register. Depends on bdfa_pkg.
module bdfa_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bdfa_req_if.sink                       req_i,
  bdfa_rsp_if.source                     rsp_o,
  input  logic [bdfa_pkg::POOL_BITS-1:0] pool_i,
  input  logic [bdfa_pkg::FIT_BITS-1:0]  fit_i,
  input  bdfa_pkg::entry_t               head_i,
  output bdfa_pkg::cell_ctrl_t           cell_ctrl_o
);
  import bdfa_pkg::*;

  ctrl_state_e state_q, state_d;

  logic [CNT_BITS-1:0]    step_q, step_d;
  logic [CNT_BITS-1:0]    live_q, live_d;
  logic                   op_q, op_d;
  logic [LEN_BITS-1:0]    need_q, need_d;
  logic [ADDR_BITS-1:0]   off_q, off_d;
  logic                   found_q, found_d;
  logic [END_BITS-1:0]    best_q, best_d;
  logic [END_BITS-1:0]    at_q, at_d;
  logic [END_BITS-1:0]    prev_end_q, prev_end_d;
  logic [POS_BITS-1:0]    pos_q, pos_d;
  logic                   rsp_valid_q, rsp_valid_d;
  logic [STATUS_BITS-1:0] rsp_status_q, rsp_status_d;
  logic [ADDR_BITS-1:0]   rsp_off_q, rsp_off_d;

  logic                 req_fire;
  logic                 table_full;
  logic                 last_step;
  logic                 commit_go;
  logic                 live_step;
  logic                 consider;
  logic [END_BITS-1:0]  region;
  logic [END_BITS-1:0]  gap_end;
  logic [END_BITS-1:0]  gap;
  logic [END_BITS-1:0]  head_end;
  logic [ADDR_BITS-1:0] head_tag;
  logic                 fits;
  logic                 take;
  logic                 match;

  assign req_fire   = req_i.valid && req_i.ready;
  assign table_full = (live_q == CNT_BITS'(MAX_BLOCKS));
  assign last_step  = (step_q == CNT_BITS'(MAX_BLOCKS - 1));
  assign commit_go  = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_o.ready);

  assign live_step = (step_q < live_q);
  assign consider  = (step_q <= live_q);
  assign region    = END_BITS'(pool_i) + END_BITS'(HEADER_BYTES);
  assign gap_end   = live_step ? END_BITS'(head_i.start) : region;
  assign gap       = (gap_end > prev_end_q) ? (gap_end - prev_end_q) : '0;
  assign head_end  = END_BITS'(head_i.start) + END_BITS'(head_i.len);
  assign head_tag  = head_i.start + ADDR_BITS'(HEADER_BYTES);
  assign fits      = consider && (gap >= END_BITS'(need_q));
  assign match     = live_step && (head_tag == off_q);

  always_comb begin
    if (fit_i == FIT_BEST) begin
      take = !found_q || (gap < best_q);
    end else if (fit_i == FIT_WORST) begin
      take = !found_q || (gap > best_q);
    end else begin
      take = !found_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.opcode == OP_ALLOC && table_full) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and cell control
  always_comb begin
    step_d       = step_q;
    live_d       = live_q;
    op_d         = op_q;
    need_d       = need_q;
    off_d        = off_q;
    found_d      = found_q;
    best_d       = best_q;
    at_d         = at_q;
    prev_end_d   = prev_end_q;
    pos_d        = pos_q;
    rsp_status_d = rsp_status_q;
    rsp_off_d    = rsp_off_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;

    cell_ctrl_o.op        = CELL_HOLD;
    cell_ctrl_o.pos       = pos_q;
    cell_ctrl_o.ins.start = at_q[ADDR_BITS-1:0];
    cell_ctrl_o.ins.len   = need_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          op_d       = req_i.opcode;
          need_d     = LEN_BITS'(req_i.request_bytes) + LEN_BITS'(HEADER_BYTES);
          off_d      = req_i.free_offset;
          found_d    = 1'b0;
          best_d     = '0;
          at_d       = '0;
          prev_end_d = '0;
          step_d     = '0;
        end
      end
      ST_SCAN: begin
        cell_ctrl_o.op = CELL_ROTATE;
        if (op_q == OP_ALLOC) begin
          if (fits && take) begin
            found_d = 1'b1;
            best_d  = gap;
            at_d    = prev_end_q;
            pos_d   = step_q[POS_BITS-1:0];
          end
        end else if (match && !found_q) begin
          found_d = 1'b1;
          pos_d   = step_q[POS_BITS-1:0];
        end
        if (live_step) begin
          prev_end_d = head_end;
        end
        step_d = step_q + CNT_BITS'(1);
      end
      ST_COMMIT: begin
        if (commit_go) begin
          rsp_valid_d = 1'b1;
          rsp_off_d   = '0;
          if (op_q == OP_ALLOC) begin
            if (found_q) begin
              cell_ctrl_o.op = CELL_INSERT;
              live_d         = live_q + CNT_BITS'(1);
              rsp_status_d   = STATUS_BITS'(STATUS_OK);
              rsp_off_d      = at_q[ADDR_BITS-1:0] + ADDR_BITS'(HEADER_BYTES);
            end else begin
              rsp_status_d = STATUS_BITS'(STATUS_NOMEM);
            end
          end else begin
            if (found_q) begin
              cell_ctrl_o.op = CELL_DELETE;
              live_d         = live_q - CNT_BITS'(1);
              rsp_status_d   = STATUS_BITS'(STATUS_OK);
            end else begin
              rsp_status_d = STATUS_BITS'(STATUS_NOT_OWNED);
            end
          end
        end
      end
      default: cell_ctrl_o.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      step_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      step_q      <= step_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    need_q       <= need_d;
    off_q        <= off_d;
    found_q      <= found_d;
    best_q       <= best_d;
    at_q         <= at_d;
    prev_end_q   <= prev_end_d;
    pos_q        <= pos_d;
    rsp_status_q <= rsp_status_d;
    rsp_off_q    <= rsp_off_d;
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.user_offset = rsp_off_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_BITS'(MAX_BLOCKS))
    else $error("live count above table size");

  a_scan_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && !last_step) |=> (step_q == $past(step_q) + CNT_BITS'(1)))
    else $error("scan step did not advance");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q != STATUS_BITS'(STATUS_OK)) |-> (rsp_off_q == '0))
    else $error("error response with nonzero offset");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != ST_IDLE))
    else $error("accepted transaction not processed");

endmodule

[hw/rtl/boundary_descriptor_fit_allocator.sv]
// Boundary-descriptor fit allocator: sorted block table in a row of cells.
// Allocate and free go through accept, scan (the row rotates once past
// the scanner) and commit, which waits for the response slot; a new
// transaction is taken only after the commit. A full-table allocate skips
// the scan. Reset clears the live count and loads config defaults; the
// table is not reset. Uses bdfa_pkg, bdfa_*_if, bdfa_cell, bdfa_ctrl.
module boundary_descriptor_fit_allocator (
  input logic        clk_i,
  input logic        rst_ni,
  bdfa_req_if.sink   req_i,
  bdfa_rsp_if.source rsp_o,
  bdfa_cfg_if.sink   cfg_i
);
  import bdfa_pkg::*;

  logic [POOL_BITS-1:0] pool_q;
  logic [FIT_BITS-1:0]  fit_q;
  cell_ctrl_t           cell_ctrl;
  entry_t               entries [MAX_BLOCKS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= POOL_RESET;
      fit_q  <= FIT_BITS'(FIT_FIRST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.reg_index)
        REG_POOL_BYTES: pool_q <= cfg_i.wdata;
        REG_FIT_MODE:   fit_q  <= cfg_i.wdata[FIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    bdfa_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (POS_BITS'(g)),
      .ctrl_i  (cell_ctrl),
      .prev_i  (entries[(g == 0) ? 0 : g - 1]),
      .next_i  (entries[(g == MAX_BLOCKS - 1) ? 0 : g + 1]),
      .entry_o (entries[g])
    );
  end

  bdfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .pool_i      (pool_q),
    .fit_i       (fit_q),
    .head_i      (entries[0]),
    .cell_ctrl_o (cell_ctrl)
  );

endmodule
